@@ rtl/tlqs_pkg.sv @@
// shared types and constants for the thick line quad setup block
`default_nettype none
package tlqs_pkg;
	localparam int COORD_BITS_DEF = 16;
	// fixed point scale of the coordinates; the datapath does not depend on it
	localparam int FRAC_BITS_DEF  = 4;
	localparam int HW_BITS        = 12;

	// control that travels down the cell row with each segment
	typedef struct packed {
		logic vld;
		logic dgn;
		logic neg_x;
		logic neg_y;
	} tlqs_ctl_t;
endpackage
`default_nettype wire

@@ rtl/thick_line_quad_setup_top.sv @@
// top level: segment in, four quad corners out, one beat per clock
//
// s_axis carries one segment per beat, m_axis one quad per beat.
// three entry stages form the differences, the squared length and the
// squared right hand sides; then a row of HW_BITS cells finds the offset
// magnitudes, one bit per cell from msb down, each cell a registered stage.
// an output register follows the last cell
// throughput: one segment per clock while m_axis_tready is high
// a stall on m_axis freezes the whole row; s_axis_tready drops whenever
// the output register holds a beat that is not taken
// reset clears all valid bits; payload registers are not reset
// degenerate is set for coincident endpoints, offsets forced to zero
// clipped is set when any corner coordinate saturated
// magnitude is round(|d_other| * t / |d|), ties away from zero, found by
// comparing (2m-1)^2 * |d|^2 against (2 * |d_other| * t)^2 in each cell,
// with m^2 * |d|^2 and m * |d|^2 carried down the row by shifts and adds
`default_nettype none
module thick_line_quad_setup_top #(
	parameter int COORD_BITS = tlqs_pkg::COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// start_x, start_y, end_x, end_y, half_width (lsb up), zero fill
	input  wire logic [((4*COORD_BITS+tlqs_pkg::HW_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// corner0_x, corner0_y .. corner3_x, corner3_y, degenerate, clipped (lsb up), zero fill
	output logic [((8*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
	import tlqs_pkg::*;
	localparam int CW  = COORD_BITS;
	localparam int DW  = CW + 1;
	localparam int SQW = 2 * DW + 1;
	localparam int RHW = DW + HW_BITS + 1;
	localparam int RSW = 2 * RHW;
	localparam int QW  = 2 * HW_BITS + SQW;
	localparam int BW  = HW_BITS + SQW;
	localparam int PW  = 4 * CW;
	localparam int N   = HW_BITS;
	localparam int OW  = ((8*CW+2+7)/8)*8;
	localparam int RW  = CW + 2;

	logic en;
	logic [OW-1:0] out_q;
	logic          ov_q;
	assign en = !ov_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = out_q;

	// entry: differences and their magnitudes
	logic signed [CW-1:0] sx, sy, ex, ey;
	logic [HW_BITS-1:0]   t;
	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0]        adx, ady;
	tlqs_ctl_t            ctl0;
	always_comb begin
		sx = s_axis_tdata[CW-1:0];
		sy = s_axis_tdata[2*CW-1:CW];
		ex = s_axis_tdata[3*CW-1:2*CW];
		ey = s_axis_tdata[4*CW-1:3*CW];
		t  = s_axis_tdata[4*CW+HW_BITS-1:4*CW];
		dx = DW'(ex) - DW'(sx);
		dy = DW'(ey) - DW'(sy);
		adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
		ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
		ctl0.vld   = s_axis_tvalid;
		ctl0.dgn   = (dx == '0) && (dy == '0);
		ctl0.neg_x = (dy > 0);
		ctl0.neg_y = dx[DW-1];
	end

	tlqs_ctl_t ctl_s1;
	logic [DW-1:0]  adx_s1, ady_s1;
	logic [PW-1:0]  pass_s1;
	logic [HW_BITS-1:0] t_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl0;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1  <= adx;
			ady_s1  <= ady;
			t_s1    <= t;
			pass_s1 <= s_axis_tdata[PW-1:0];
		end
	end

	// squared length and the unsquared right hand sides
	tlqs_ctl_t      ctl_s2;
	logic [SQW-1:0] sq_s2;
	logic [RHW-1:0] rhx_s2, rhy_s2;
	logic [PW-1:0]  pass_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2   <= SQW'(adx_s1) * SQW'(adx_s1) + SQW'(ady_s1) * SQW'(ady_s1);
			rhx_s2  <= RHW'(ady_s1) * RHW'(t_s1) << 1;
			rhy_s2  <= RHW'(adx_s1) * RHW'(t_s1) << 1;
			pass_s2 <= pass_s1;
		end
	end

	// squared right hand sides
	tlqs_ctl_t      ctl_s3;
	logic [SQW-1:0] sq_s3;
	logic [RSW-1:0] rsx_s3, rsy_s3;
	logic [PW-1:0]  pass_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3   <= sq_s2;
			rsx_s3  <= RSW'(rhx_s2) * RSW'(rhx_s2);
			rsy_s3  <= RSW'(rhy_s2) * RSW'(rhy_s2);
			pass_s3 <= pass_s2;
		end
	end

	tlqs_ctl_t          ctl_c [N+1];
	logic [SQW-1:0]     sq_c  [N+1];
	logic [RSW-1:0]     rsx_c [N+1], rsy_c [N+1];
	logic [HW_BITS-1:0] mx_c  [N+1], my_c [N+1];
	logic [QW-1:0]      qx_c  [N+1], qy_c [N+1];
	logic [BW-1:0]      lx_c  [N+1], ly_c [N+1];
	logic [PW-1:0]      pass_c[N+1];
	assign ctl_c[0]  = ctl_s3;
	assign sq_c[0]   = sq_s3;
	assign rsx_c[0]  = rsx_s3;
	assign rsy_c[0]  = rsy_s3;
	assign mx_c[0]   = '0;
	assign my_c[0]   = '0;
	assign qx_c[0]   = '0;
	assign qy_c[0]   = '0;
	assign lx_c[0]   = '0;
	assign ly_c[0]   = '0;
	assign pass_c[0] = pass_s3;

	for (genvar i = 0; i < N; i++) begin : g_cell
		tlqs_cell #(.SQW(SQW), .RSW(RSW), .BIT(N-1-i), .PW(PW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctl_in(ctl_c[i]), .sq_in(sq_c[i]), .rsx_in(rsx_c[i]), .rsy_in(rsy_c[i]),
			.mx_in(mx_c[i]), .my_in(my_c[i]), .qx_in(qx_c[i]), .qy_in(qy_c[i]),
			.lx_in(lx_c[i]), .ly_in(ly_c[i]), .pass_in(pass_c[i]),
			.ctl_q(ctl_c[i+1]), .sq_q(sq_c[i+1]), .rsx_q(rsx_c[i+1]),
			.rsy_q(rsy_c[i+1]), .mx_q(mx_c[i+1]), .my_q(my_c[i+1]),
			.qx_q(qx_c[i+1]), .qy_q(qy_c[i+1]), .lx_q(lx_c[i+1]), .ly_q(ly_c[i+1]),
			.pass_q(pass_c[i+1])
		);
	end

	// corner formation with saturation
	tlqs_ctl_t cf;
	logic signed [RW-1:0] ox, oy;
	logic signed [RW-1:0] v [8];
	logic [CW-1:0]        r [8];
	logic [7:0]           sat;
	logic [OW-1:0]        nxt;
	localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 <<< (CW-1)) - 1);
	localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);
	always_comb begin
		cf = ctl_c[N];
		ox = cf.dgn ? '0 : (cf.neg_x ? -RW'(mx_c[N]) : RW'(mx_c[N]));
		oy = cf.dgn ? '0 : (cf.neg_y ? -RW'(my_c[N]) : RW'(my_c[N]));
		v[0] = RW'($signed(pass_c[N][CW-1:0]))      - ox;
		v[1] = RW'($signed(pass_c[N][2*CW-1:CW]))   - oy;
		v[2] = RW'($signed(pass_c[N][CW-1:0]))      + ox;
		v[3] = RW'($signed(pass_c[N][2*CW-1:CW]))   + oy;
		v[4] = RW'($signed(pass_c[N][3*CW-1:2*CW])) - ox;
		v[5] = RW'($signed(pass_c[N][4*CW-1:3*CW])) - oy;
		v[6] = RW'($signed(pass_c[N][3*CW-1:2*CW])) + ox;
		v[7] = RW'($signed(pass_c[N][4*CW-1:3*CW])) + oy;
		nxt = '0;
		for (int k = 0; k < 8; k++) begin
			sat[k] = (v[k] > MAXV) || (v[k] < MINV);
			r[k] = (v[k] > MAXV) ? MAXV[CW-1:0] : (v[k] < MINV) ? MINV[CW-1:0] : v[k][CW-1:0];
			nxt[k*CW +: CW] = r[k];
		end
		nxt[8*CW]   = cf.dgn;
		nxt[8*CW+1] = |sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= cf.vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= nxt;
		end
	end

	// a held beat is not replaced while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !m_axis_tready |=> ov_q && $stable(out_q))
		else $error("held beat changed");
	// degenerate output never shows an offset
	assert property (@(posedge clk) disable iff (!arst_n)
		cf.vld && cf.dgn |-> ox == '0 && oy == '0)
		else $error("offset on degenerate segment");
	// ready only while the row can move
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!ov_q || m_axis_tready))
		else $error("ready mismatch");
endmodule
`default_nettype wire

@@ rtl/tlqs_cell.sv @@
// one cell of the row: decides one bit of both offset magnitudes
`default_nettype none
module tlqs_cell #(
	parameter int SQW = 35,
	parameter int RSW = 60,
	parameter int BIT = 0,
	parameter int PW  = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire tlqs_pkg::tlqs_ctl_t  ctl_in,
	input  wire logic [SQW-1:0]       sq_in,
	input  wire logic [RSW-1:0]       rsx_in,
	input  wire logic [RSW-1:0]       rsy_in,
	input  wire logic [tlqs_pkg::HW_BITS-1:0] mx_in,
	input  wire logic [tlqs_pkg::HW_BITS-1:0] my_in,
	input  wire logic [2*tlqs_pkg::HW_BITS+SQW-1:0] qx_in,
	input  wire logic [2*tlqs_pkg::HW_BITS+SQW-1:0] qy_in,
	input  wire logic [tlqs_pkg::HW_BITS+SQW-1:0]   lx_in,
	input  wire logic [tlqs_pkg::HW_BITS+SQW-1:0]   ly_in,
	input  wire logic [PW-1:0]        pass_in,
	output tlqs_pkg::tlqs_ctl_t       ctl_q,
	output logic [SQW-1:0]            sq_q,
	output logic [RSW-1:0]            rsx_q,
	output logic [RSW-1:0]            rsy_q,
	output logic [tlqs_pkg::HW_BITS-1:0] mx_q,
	output logic [tlqs_pkg::HW_BITS-1:0] my_q,
	output logic [2*tlqs_pkg::HW_BITS+SQW-1:0] qx_q,
	output logic [2*tlqs_pkg::HW_BITS+SQW-1:0] qy_q,
	output logic [tlqs_pkg::HW_BITS+SQW-1:0]   lx_q,
	output logic [tlqs_pkg::HW_BITS+SQW-1:0]   ly_q,
	output logic [PW-1:0]             pass_q
);
	import tlqs_pkg::*;
	localparam int QW = 2 * HW_BITS + SQW;
	localparam int BW = HW_BITS + SQW;
	localparam int LW = QW + 2;
	// q holds m^2 * sq and l holds m * sq for the bits decided so far
	// test (2m-1)^2 * sq <= rhs with m = current | bit; keep the bit if it fits
	logic [QW-1:0] qx_c, qy_c;
	logic [BW-1:0] lx_c, ly_c;
	logic [LW-1:0] tx, ty;
	logic          fit_x, fit_y;
	always_comb begin
		// (m + 2^b)^2 sq = m^2 sq + 2^(b+1) m sq + 2^(2b) sq
		qx_c = qx_in + (QW'(lx_in) << (BIT + 1)) + (QW'(sq_in) << (2 * BIT));
		qy_c = qy_in + (QW'(ly_in) << (BIT + 1)) + (QW'(sq_in) << (2 * BIT));
		lx_c = lx_in + (BW'(sq_in) << BIT);
		ly_c = ly_in + (BW'(sq_in) << BIT);
		// (2m-1)^2 sq = 4 m^2 sq - 4 m sq + sq
		tx = (LW'(qx_c) << 2) - (LW'(lx_c) << 2) + LW'(sq_in);
		ty = (LW'(qy_c) << 2) - (LW'(ly_c) << 2) + LW'(sq_in);
		fit_x = (tx <= LW'(rsx_in));
		fit_y = (ty <= LW'(rsy_in));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_q   <= sq_in;
			rsx_q  <= rsx_in;
			rsy_q  <= rsy_in;
			pass_q <= pass_in;
			mx_q   <= fit_x ? (mx_in | (HW_BITS'(1) << BIT)) : mx_in;
			my_q   <= fit_y ? (my_in | (HW_BITS'(1) << BIT)) : my_in;
			qx_q   <= fit_x ? qx_c : qx_in;
			qy_q   <= fit_y ? qy_c : qy_in;
			lx_q   <= fit_x ? lx_c : lx_in;
			ly_q   <= fit_y ? ly_c : ly_in;
		end
	end
endmodule
`default_nettype wire

@@ bench/tb_thick_line_quad_setup_top.sv @@
// testbench for the thick line quad setup block: directed and random segments, self-checking
`timescale 1ns / 100ps
`default_nettype none
module tb_thick_line_quad_setup_top;
	import tlqs_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int IN_W = ((4*CB+HW_BITS+7)/8)*8;
	localparam int OUT_W = ((8*CB+2+7)/8)*8;
	localparam int LATENCY = HW_BITS + 4;
	localparam longint LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	typedef struct packed {
		logic [HW_BITS-1:0] half_width;
		logic signed [CB-1:0] end_y;
		logic signed [CB-1:0] end_x;
		logic signed [CB-1:0] start_y;
		logic signed [CB-1:0] start_x;
	} segment_t;

	typedef struct packed {
		logic clipped;
		logic degenerate;
		logic signed [CB-1:0] c3y, c3x, c2y, c2x, c1y, c1x, c0y, c0x;
	} quad_t;

	segment_t pending_segs[$];
	quad_t expected_quads[$];
	int errors = 0;
	longint cycle = 0;
	int send_idle_pct = 36;
	int recv_idle_pct = 60;
	bit hold_recv = 1'b0;
	bit stim_done = 1'b0;

	thick_line_quad_setup_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// round(num * t / |d|), ties away from zero, by binary search on squares
	function automatic longint offset_mag(longint num, longint ax, longint ay, longint t);
		longint lo, hi, mid, k;
		logic [127:0] lhs, rhs;
		lo = 0;
		hi = t;
		rhs = 128'(2 * num * t) * 128'(2 * num * t);
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			k = 2 * mid - 1;
			lhs = 128'(k * ax) * 128'(k * ax) + 128'(k * ay) * 128'(k * ay);
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic logic [CB-1:0] sat_coord(longint v, ref logic sat);
		longint maxv, minv;
		maxv = (64'sd1 <<< (CB-1)) - 1;
		minv = -maxv - 1;
		if (v > maxv) begin
			sat = 1'b1;
			return maxv[CB-1:0];
		end
		if (v < minv) begin
			sat = 1'b1;
			return minv[CB-1:0];
		end
		return v[CB-1:0];
	endfunction

	function automatic quad_t expand_segment(segment_t s);
		quad_t q;
		longint sx, sy, ex, ey, dx, dy, ox, oy, mx, my, adx, ady, t;
		logic sat;
		sx = longint'(s.start_x); sy = longint'(s.start_y);
		ex = longint'(s.end_x); ey = longint'(s.end_y);
		t = longint'(s.half_width);
		dx = ex - sx;
		dy = ey - sy;
		ox = 0;
		oy = 0;
		sat = 1'b0;
		q.degenerate = (dx == 0 && dy == 0);
		if (!q.degenerate) begin
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			mx = offset_mag(ady, adx, ady, t);
			my = offset_mag(adx, adx, ady, t);
			ox = dy > 0 ? -mx : mx;
			oy = dx < 0 ? -my : my;
		end
		q.c0x = sat_coord(sx - ox, sat);
		q.c0y = sat_coord(sy - oy, sat);
		q.c1x = sat_coord(sx + ox, sat);
		q.c1y = sat_coord(sy + oy, sat);
		q.c2x = sat_coord(ex - ox, sat);
		q.c2y = sat_coord(ey - oy, sat);
		q.c3x = sat_coord(ex + ox, sat);
		q.c3y = sat_coord(ey + oy, sat);
		q.clipped = sat;
		return q;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, field, got, want);
		errors++;
	endtask

	function automatic segment_t rand_segment();
		segment_t s;
		int mode;
		logic [95:0] rbits;
		mode = $urandom_range(0, 9);
		rbits = {$urandom, $urandom, $urandom};
		s = segment_t'(rbits[$bits(segment_t)-1:0]);
		if (mode < 4) begin
			// moderate coordinates, typical geometry
			s.start_x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			s.start_y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			s.end_x = s.start_x + $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
			s.end_y = s.start_y + $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
		end else if (mode == 4) begin
			s.end_x = s.start_x;
			s.end_y = s.start_y;
		end else if (mode == 5) begin
			s.end_y = s.start_y;
		end else if (mode == 6) begin
			s.end_x = s.start_x;
		end else if (mode == 7) begin
			// short segment, dx positive and dy negative
			s.end_x = s.start_x + 16'($urandom_range(1, 40));
			s.end_y = s.start_y - 16'($urandom_range(1, 40));
		end
		return s;
	endfunction

	// driver: one beat offered per cycle unless idling; a beat not taken stays offered
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_quads.push_back(expand_segment(segment_t'(s_axis_tdata[4*CB+HW_BITS-1:0])));
			void'(pending_segs.pop_front());
		end
		if (pending_segs.size() > 0 && ($urandom_range(0, 99) >= send_idle_pct)) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= IN_W'(pending_segs[0]);
		end else if (!(s_axis_tvalid && !s_axis_tready)) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			s_axis_tvalid <= 1'b1;
		end
	end

	// monitor and receiver idling
	always @(posedge clk) begin
		quad_t got, want;
		cycle <= cycle + 1;
		m_axis_tready <= !hold_recv && ($urandom_range(0, 99) >= recv_idle_pct);
		if (m_axis_tvalid && m_axis_tready) begin
			got = quad_t'(m_axis_tdata[8*CB+1:0]);
			if (expected_quads.size() == 0) begin
				$display("unexpected quad beat at cycle %0d", cycle);
				errors++;
			end else begin
				want = expected_quads.pop_front();
				if (got.c0x !== want.c0x)
					report_mismatch("corner0_x", longint'(got.c0x), longint'(want.c0x));
				if (got.c0y !== want.c0y)
					report_mismatch("corner0_y", longint'(got.c0y), longint'(want.c0y));
				if (got.c1x !== want.c1x)
					report_mismatch("corner1_x", longint'(got.c1x), longint'(want.c1x));
				if (got.c1y !== want.c1y)
					report_mismatch("corner1_y", longint'(got.c1y), longint'(want.c1y));
				if (got.c2x !== want.c2x)
					report_mismatch("corner2_x", longint'(got.c2x), longint'(want.c2x));
				if (got.c2y !== want.c2y)
					report_mismatch("corner2_y", longint'(got.c2y), longint'(want.c2y));
				if (got.c3x !== want.c3x)
					report_mismatch("corner3_x", longint'(got.c3x), longint'(want.c3x));
				if (got.c3y !== want.c3y)
					report_mismatch("corner3_y", longint'(got.c3y), longint'(want.c3y));
				if (got.degenerate !== want.degenerate)
					report_mismatch("degenerate", longint'(got.degenerate),
						longint'(want.degenerate));
				if (got.clipped !== want.clipped)
					report_mismatch("clipped", longint'(got.clipped), longint'(want.clipped));
			end
		end
		if (cycle >= LIMIT) begin
			$display("tb_thick_line_quad_setup_top NOT OK");
			$finish;
		end
	end

	// long receiver hold-off, counted in its own process
	initial begin
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_recv = 1'b1;
		repeat (60) @(posedge clk);
		hold_recv = 1'b0;
	end

	task automatic add_seg(int sx, int sy, int ex, int ey, int hw);
		segment_t s;
		s.start_x = CB'(sx); s.start_y = CB'(sy); s.end_x = CB'(ex); s.end_y = CB'(ey);
		s.half_width = HW_BITS'(hw);
		pending_segs.push_back(s);
	endtask

	task automatic wait_drained();
		while (pending_segs.size() > 0 || s_axis_tvalid || expected_quads.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, coincident endpoints, zero width, saturation
		add_seg(0, 0, 0, 0, 100);
		add_seg(-32768, -32768, -32768, -32768, 4095);
		add_seg(100, 200, 300, 200, 0);
		add_seg(0, 0, 16, 0, 16);
		add_seg(0, 0, 0, 16, 16);
		add_seg(0, 0, -16, 0, 16);
		add_seg(0, 0, 0, -16, 16);
		add_seg(0, 0, 3, 4, 5);
		add_seg(0, 0, 1, 1, 1);
		add_seg(0, 0, 2, 2, 3);
		add_seg(32767, 32767, 32767, -32768, 4095);
		add_seg(-32768, -32768, 32767, -32768, 4095);
		add_seg(-32768, 32767, 32767, -32768, 4095);
		add_seg(32767, 0, -32768, 0, 4095);
		add_seg(32000, 32000, 32100, 32050, 2048);
		add_seg(-1, -1, 0, 0, 4095);
		add_seg(1, -1, -1, 1, 1);
		add_seg(-21846, 21845, 21845, -21846, 2730);
		wait_drained();
		// sender pause: nothing outstanding, let the pipe empty
		repeat (LATENCY + 4) @(posedge clk);
		for (int i = 0; i < 450; i++) pending_segs.push_back(rand_segment());
		wait_drained();
		send_idle_pct = 60;
		recv_idle_pct = 36;
		for (int i = 0; i < 450; i++) pending_segs.push_back(rand_segment());
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 450; i++) pending_segs.push_back(rand_segment());
		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0)
			$display("tb_thick_line_quad_setup_top OK");
		else
			$display("tb_thick_line_quad_setup_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
